// ===== rtl/core/cpf_pkg.sv =====
// Shared constants for the coincidence pair finder.
// Holds the finder mode codes and the configuration register map; no dependencies.
package cpf_pkg;

    localparam int WINDOW_BITS   = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH     = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REJECT_SAME_HEAD = 1'd1;

    localparam int MODE_BITS = 2;

    localparam logic [MODE_BITS-1:0] MODE_EMPTY  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ANCHOR = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PAIR   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_SKIP   = 2'd3;

endpackage

// ===== rtl/core/cpf_engine.sv =====
// Finder state and per-hit decision logic of the coincidence pair finder.
// Depends on cpf_pkg for the mode codes and the window width.
module cpf_engine
    import cpf_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int SCINT_BITS = 12,
    parameter int HEAD_BITS  = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [TIME_BITS-1:0]   hit_time,
    input  logic [SCINT_BITS-1:0]  scint_index,
    input  logic [HEAD_BITS-1:0]   head_index,
    input  logic                   last_hit,
    input  logic [WINDOW_BITS-1:0] window_width,
    input  logic                   reject_same_head,
    output logic                   emit,
    output logic [TIME_BITS-1:0]   first_time,
    output logic [SCINT_BITS-1:0]  first_scint,
    output logic [TIME_BITS-1:0]   second_time,
    output logic [SCINT_BITS-1:0]  second_scint
);

    localparam int CMP_BITS = ((TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS) + 1;

    logic [MODE_BITS-1:0]  mode_reg;
    logic [MODE_BITS-1:0]  mode_next;
    logic [TIME_BITS-1:0]  anchor_time_reg;
    logic [TIME_BITS-1:0]  anchor_time_next;
    logic [SCINT_BITS-1:0] anchor_scint_reg;
    logic [SCINT_BITS-1:0] anchor_scint_next;
    logic [HEAD_BITS-1:0]  anchor_head_reg;
    logic [HEAD_BITS-1:0]  anchor_head_next;
    logic [TIME_BITS-1:0]  partner_time_reg;
    logic [TIME_BITS-1:0]  partner_time_next;
    logic [SCINT_BITS-1:0] partner_scint_reg;
    logic [SCINT_BITS-1:0] partner_scint_next;
    logic [HEAD_BITS-1:0]  partner_head_reg;
    logic [HEAD_BITS-1:0]  partner_head_next;
    logic [CMP_BITS-1:0]   bound;
    logic                  in_window;
    logic                  pair_ok;

    // A hit earlier than the anchor also satisfies this bound.
    assign bound     = CMP_BITS'(anchor_time_reg) + CMP_BITS'(window_width);
    assign in_window = CMP_BITS'(hit_time) <= bound;
    assign pair_ok   = !(reject_same_head && (anchor_head_reg == partner_head_next));

    always_comb
    begin
        mode_next          = mode_reg;
        anchor_time_next   = anchor_time_reg;
        anchor_scint_next  = anchor_scint_reg;
        anchor_head_next   = anchor_head_reg;
        partner_time_next  = partner_time_reg;
        partner_scint_next = partner_scint_reg;
        partner_head_next  = partner_head_reg;
        emit               = 1'b0;
        case (mode_reg)
            MODE_EMPTY:
            begin
                mode_next         = MODE_ANCHOR;
                anchor_time_next  = hit_time;
                anchor_scint_next = scint_index;
                anchor_head_next  = head_index;
            end
            MODE_ANCHOR:
            begin
                if (!in_window)
                begin
                    anchor_time_next  = hit_time;
                    anchor_scint_next = scint_index;
                    anchor_head_next  = head_index;
                end
                else if (scint_index == anchor_scint_reg)
                begin
                    mode_next = MODE_SKIP;
                end
                else
                begin
                    mode_next          = MODE_PAIR;
                    partner_time_next  = hit_time;
                    partner_scint_next = scint_index;
                    partner_head_next  = head_index;
                end
            end
            MODE_PAIR:
            begin
                if (!in_window)
                begin
                    emit              = pair_ok;
                    mode_next         = MODE_ANCHOR;
                    anchor_time_next  = hit_time;
                    anchor_scint_next = scint_index;
                    anchor_head_next  = head_index;
                end
                else
                begin
                    mode_next = MODE_SKIP;
                end
            end
            default:
            begin
                if (!in_window)
                begin
                    mode_next         = MODE_ANCHOR;
                    anchor_time_next  = hit_time;
                    anchor_scint_next = scint_index;
                    anchor_head_next  = head_index;
                end
            end
        endcase
        // The final hit flushes a pair that is still pending and empties the finder.
        if (last_hit)
        begin
            if (mode_next == MODE_PAIR)
            begin
                emit = pair_ok;
            end
            mode_next = MODE_EMPTY;
        end
    end

    // An emitted pair always has the current anchor as its first hit.
    assign first_time   = anchor_time_reg;
    assign first_scint  = anchor_scint_reg;
    assign second_time  = partner_time_next;
    assign second_scint = partner_scint_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EMPTY;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            anchor_time_reg   <= anchor_time_next;
            anchor_scint_reg  <= anchor_scint_next;
            anchor_head_reg   <= anchor_head_next;
            partner_time_reg  <= partner_time_next;
            partner_scint_reg <= partner_scint_next;
            partner_head_reg  <= partner_head_next;
        end
    end

endmodule

// ===== rtl/core/coincidence_pair_finder.sv =====
// Top level of the coincidence pair finder: input register, finder engine, result register.
// Depends on cpf_pkg and cpf_engine.
//
//   Channel   Direction  Carries
//   s_axis    in         one detector hit per request (time, scintillator, head; tlast = last hit)
//   m_axis    out        one coincidence pair per request (anchor hit and partner hit)
//   cfg       in         register writes, window_width and reject_same_head
//
// A hit waits in the input register until the finder steps, and a pair goes through the
// result register to m_axis; one hit can be taken every cycle while m_axis does not stall.
// The finder steps only when the result register is free or being drained, so a
// stall on m_axis holds the input register and then s_axis_tready.
// Reset clears the finder mode, the valid flags and the configuration registers.
module coincidence_pair_finder
    import cpf_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int SCINT_BITS = 12,
    parameter int HEAD_BITS  = 4,
    localparam int IN_BITS   = TIME_BITS + SCINT_BITS + HEAD_BITS,
    localparam int OUT_BITS  = 2 * (TIME_BITS + SCINT_BITS),
    localparam int IN_BYTES  = (IN_BITS + 7) / 8,
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // hit_time, scint_index, head_index, zero fill
    input  logic [IN_BYTES*8-1:0]    s_axis_tdata,
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // first_time, first_scint, second_time, second_scint, zero fill
    output logic [OUT_BYTES*8-1:0]   m_axis_tdata,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic                   in_valid_reg;
    logic [IN_BITS-1:0]     in_data_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_BITS-1:0]    out_data_reg;
    logic [WINDOW_BITS-1:0] window_reg;
    logic                   reject_reg;
    logic                   advance;
    logic                   emit;
    logic [TIME_BITS-1:0]   first_time;
    logic [SCINT_BITS-1:0]  first_scint;
    logic [TIME_BITS-1:0]   second_time;
    logic [SCINT_BITS-1:0]  second_scint;

    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign out_valid_next = advance ? emit : (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
            reject_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_WIDTH:     window_reg <= cfg_data[WINDOW_BITS-1:0];
                    REG_REJECT_SAME_HEAD: reject_reg <= cfg_data[0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
            in_last_reg <= s_axis_tlast;
        end
        if (advance && emit)
        begin
            out_data_reg <= {second_scint, second_time, first_scint, first_time};
        end
    end

    cpf_engine #(
        .TIME_BITS  (TIME_BITS),
        .SCINT_BITS (SCINT_BITS),
        .HEAD_BITS  (HEAD_BITS)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .hit_time         (in_data_reg[TIME_BITS-1:0]),
        .scint_index      (in_data_reg[TIME_BITS +: SCINT_BITS]),
        .head_index       (in_data_reg[TIME_BITS+SCINT_BITS +: HEAD_BITS]),
        .last_hit         (in_last_reg),
        .window_width     (window_reg),
        .reject_same_head (reject_reg),
        .emit             (emit),
        .first_time       (first_time),
        .first_scint      (first_scint),
        .second_time      (second_time),
        .second_scint     (second_scint)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = (OUT_BYTES*8)'(out_data_reg);

endmodule
